@@ hdl/torep_pkg.sv @@
package torep_pkg;

  // Largest supported site count; the flag table holds one bit per index.
  localparam int unsigned MaxSites = 16;
  localparam int unsigned TableAw  = MaxSites;
  localparam int unsigned TableDepth = 1 << MaxSites;

  localparam int unsigned IndexW = 16;
  localparam int unsigned SiteW  = 5;
  localparam int unsigned ApbAw  = 4;
  localparam int unsigned ApbDw  = 32;

  typedef enum logic [1:0] {
    RegSiteCount       = 2'd0,
    RegGroupLength     = 2'd1,
    RegDirection       = 2'd2,
    RegMomentumNonzero = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OpLoad    = 1'b0,
    OpProcess = 1'b1
  } op_e;

  typedef struct packed {
    logic              operation;
    logic [IndexW-1:0] index;
    logic              flag;
  } in_item_t;

  typedef struct packed {
    logic             representative;
    logic [SiteW-1:0] orbit_length;
  } out_item_t;

endpackage

@@ hdl/translation_orbit_representatives_core.sv @@
// Translation orbit representative finder.
// Items arrive on in_valid_i/in_ready_o/in_data_i. A load transaction writes
// one bit of the basis flag table; a process transaction looks up the flag of
// its index and, if set, walks the orbit of the index under the configured
// rotation, clearing every member, then writes the keep bit back at the index.
// Each item returns exactly one result on out_valid_o/out_ready_i/out_data_o.
// A load writes its flag bit when accepted, then finishes; a process item reads
// its flag, then goes straight to the finish step if the flag is clear or its
// index or configuration is unusable, else walks its orbit first. The orbit walk
// issues one table write per cycle through the single write port of the flag memory.
// Results pass through an output register, so a new item is taken while a
// finished result still waits; if the receiver stalls, the block holds its next
// result in the finish step until the output register frees up. Reset returns
// the configuration registers to their defaults (16 sites, group length 4,
// horizontal mode, zero momentum) and idles the control. The flag table is not
// cleared: entries must be loaded before they are read. Configuration is to be
// written through the APB port only while idle; the block does not enforce this.
module translation_orbit_representatives_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  torep_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output torep_pkg::out_item_t            out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [torep_pkg::ApbAw-1:0]     paddr,
  input  logic [torep_pkg::ApbDw-1:0]     pwdata,
  output logic [torep_pkg::ApbDw-1:0]     prdata,
  output logic                            pready
);

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SRead = 4'b0010,
    SWalk = 4'b0100,
    SFin  = 4'b1000
  } state_e;

  localparam int unsigned Iw = torep_pkg::IndexW;
  localparam int unsigned Sw = torep_pkg::SiteW;

  state_e state_q, state_d;

  logic [Sw-1:0] site_count_q, group_length_q;
  logic          direction_q, momentum_nonzero_q;

  logic [Iw-1:0] idx_q, idx_d;
  logic [Iw-1:0] j_q, j_d;
  logic [Sw-1:0] steps_q, steps_d;
  logic          wb_q, wb_d;
  torep_pkg::out_item_t res_q, res_d;

  logic                 out_valid_q, out_valid_d;
  torep_pkg::out_item_t out_data_q, out_data_d;

  logic cfg_we;
  logic in_acc;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q       <= Sw'(16);
      group_length_q     <= Sw'(4);
      direction_q        <= 1'b0;
      momentum_nonzero_q <= 1'b0;
    end else if (cfg_we) begin
      case (torep_pkg::reg_idx_e'(paddr[3:2]))
        torep_pkg::RegSiteCount:       site_count_q       <= pwdata[Sw-1:0];
        torep_pkg::RegGroupLength:     group_length_q     <= pwdata[Sw-1:0];
        torep_pkg::RegDirection:       direction_q        <= pwdata[0];
        torep_pkg::RegMomentumNonzero: momentum_nonzero_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (torep_pkg::reg_idx_e'(paddr[3:2]))
      torep_pkg::RegSiteCount:       prdata[Sw-1:0] = site_count_q;
      torep_pkg::RegGroupLength:     prdata[Sw-1:0] = group_length_q;
      torep_pkg::RegDirection:       prdata[0]      = direction_q;
      torep_pkg::RegMomentumNonzero: prdata[0]      = momentum_nonzero_q;
      default:                       prdata         = '0;
    endcase
  end

  // Configuration decode: group start positions and whether the group length
  // divides the site count. Each multiple of the group length is a constant
  // times a 5-bit value, so the products are independent and narrow.
  logic [Iw-1:0] start_m;
  logic          divides;
  logic          cfg_ok;
  logic [Iw-1:0] n_mask;
  logic [9:0]    prod;

  always_comb begin
    start_m = '0;
    divides = 1'b0;
    prod    = '0;
    for (int k = 0; k <= int'(torep_pkg::MaxSites); k++) begin
      prod = 10'(k) * {5'b0, group_length_q};
      if (prod < {5'b0, site_count_q} && k < int'(torep_pkg::MaxSites)) begin
        start_m[prod[3:0]] = 1'b1;
      end
      if (k != 0 && prod == {5'b0, site_count_q}) begin
        divides = 1'b1;
      end
    end
  end

  assign cfg_ok = (site_count_q != '0) && (site_count_q <= Sw'(torep_pkg::MaxSites)) &&
                  (group_length_q != '0) && (group_length_q <= site_count_q) && divides;
  assign n_mask = Iw'((17'd1 << site_count_q) - 17'd1);

  // One rotation step of the orbit walk.
  logic [Iw-1:0] rot_rows, rot_whole, j_next;
  assign rot_rows  = (((j_q << 1) & ~start_m) | ((j_q >> (group_length_q - Sw'(1))) & start_m))
                     & n_mask;
  assign rot_whole = ((j_q << group_length_q) | (j_q >> (site_count_q - group_length_q)))
                     & n_mask;
  assign j_next    = direction_q ? rot_whole : rot_rows;

  // Flag table.
  logic                          ram_we, ram_wdata, ram_rdata;
  logic [torep_pkg::TableAw-1:0] ram_waddr, ram_raddr;

  assign ram_raddr = in_data_i.index[torep_pkg::TableAw-1:0];

  torep_ram #(
    .Width(1),
    .Depth(torep_pkg::TableDepth)
  ) u_flags (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == SIdle);
  assign in_acc     = in_valid_i & in_ready_o;

  logic walk_done;
  logic keep;
  assign walk_done = (j_next == idx_q) || (steps_q + Sw'(1) == Sw'(torep_pkg::MaxSites));
  assign keep      = !((steps_q == '0) && momentum_nonzero_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    j_d         = j_q;
    steps_d     = steps_q;
    wb_d        = wb_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[torep_pkg::TableAw-1:0];
    ram_wdata   = 1'b0;

    case (state_q)
      SIdle: begin
        if (in_acc) begin
          idx_d   = in_data_i.index;
          j_d     = in_data_i.index;
          steps_d = '0;
          wb_d    = 1'b0;
          res_d   = '0;
          if (in_data_i.operation == torep_pkg::OpLoad) begin
            ram_we    = 1'b1;
            ram_waddr = in_data_i.index[torep_pkg::TableAw-1:0];
            ram_wdata = in_data_i.flag;
            state_d   = SFin;
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        if (cfg_ok && ((idx_q & ~n_mask) == '0) && ram_rdata) begin
          state_d = SWalk;
        end else begin
          state_d = SFin;
        end
      end
      SWalk: begin
        ram_we    = 1'b1;
        ram_waddr = j_next[torep_pkg::TableAw-1:0];
        ram_wdata = 1'b0;
        j_d       = j_next;
        steps_d   = steps_q + Sw'(1);
        if (walk_done) begin
          wb_d                 = 1'b1;
          res_d.representative = keep;
          res_d.orbit_length   = steps_q + Sw'(1);
          state_d              = SFin;
        end
      end
      SFin: begin
        // The keep bit goes back at the index; repeating it while stalled is harmless.
        ram_we    = wb_q;
        ram_waddr = idx_q[torep_pkg::TableAw-1:0];
        ram_wdata = res_q.representative;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      wb_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wb_q        <= wb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    j_q        <= j_d;
    steps_q    <= steps_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWalk) |-> (steps_q < Sw'(torep_pkg::MaxSites)))
    else $error("orbit walk ran past the site limit");

  a_load_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.operation == torep_pkg::OpLoad) |=> (state_q == SFin))
    else $error("load transaction did not go straight to finish");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == SFin))
    else $error("result posted outside the finish step");

  a_walk_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWalk) |-> (ram_we && !ram_wdata))
    else $error("orbit walk step without a clearing write");
`endif

endmodule

@@ hdl/torep_ram.sv @@
module torep_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
